// File: sv/gb8_pkg.sv
// shared types, constants and codes for the 8x8 glyph blitter
`default_nettype none
package gb8_pkg;

  // cell size walked per glyph, clamped to the 8-bit row stride
  localparam int GLYPH_SIZE = 8;
  localparam int ROW_STRIDE = 8;
  localparam int CELL = (GLYPH_SIZE > ROW_STRIDE) ? ROW_STRIDE : GLYPH_SIZE;
  localparam int PIXELS = ROW_STRIDE * ROW_STRIDE;
  localparam int COL_W = $clog2(ROW_STRIDE);

  localparam logic [31:0] TRANSPARENT = 32'hFFFF_FFFF;
  localparam logic [5:0]  BPP_24 = 6'd24;
  localparam logic [5:0]  BPP_32 = 6'd32;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_ROW_PITCH     = 3'd2,
    REG_BPP           = 3'd3,
    REG_FRAME_BASE    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  char_code;
    logic [63:0] glyph_bits;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [31:0] fore_color;
    logic [31:0] back_color;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] write_address;
    logic [23:0] write_color;
    logic        last_write;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_PREP = 2'd1,
    ST_RUN  = 2'd2
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rem_zero;
    logic step_ok;
  } sts_t;

endpackage
`default_nettype wire

// File: sv/glyph_blit_8x8_top.sv
// top level of the 8x8 glyph blitter
// Usage:
//  - in channel: one draw-character command per beat (code, glyph rows,
//    origin, fore and back colors); in_stall is low only while idle.
//  - out channel: one framebuffer write per beat (address, 24-bit color,
//    last_write on the final write of the command).
//  - cfg port: plain write, cfg_we with cfg_index and cfg_wdata; write only
//    while no command is in flight.
// Timing:
//  - the in beat loads the command, then the prep state computes the row
//    address (the single origin_y times pitch multiply)
//  - then the 64-pixel walk steps through the pixel positions in order up to
//    the last pixel written, halting on receiver stalls; out_valid rises
//    from the output register after the prep state and the first writing
//    pixel of the walk
//  - the walk is the limiting loop: at most one write per cycle
// Reset (synchronous, rst_n low) clears the config registers to zero,
// returns the controller to idle and drops out_valid.
// When the receiver stalls, the finished write waits in the output register
// and the walk halts at the next pixel that would write.
`default_nettype none
module glyph_blit_8x8_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire gb8_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output gb8_pkg::out_beat_t     out_data,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_wdata
);
  import gb8_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller
  gb8_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  gb8_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: sv/gb8_ctrl.sv
// controller state machine for the glyph blitter
`default_nettype none
module gb8_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire gb8_pkg::sts_t sts,
  output gb8_pkg::cmd_t     cmd
);
  import gb8_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (sts.rem_zero) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.step = sts.step_ok;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/gb8_dp.sv
// datapath: config registers, pixel mask, address walk and output register
`default_nettype none
module gb8_dp (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [31:0]      cfg_wdata,
  input  wire gb8_pkg::in_beat_t in_data,
  input  wire gb8_pkg::cmd_t    cmd,
  output gb8_pkg::sts_t         sts,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output gb8_pkg::out_beat_t    out_data
);
  import gb8_pkg::*;

  logic [15:0] width_r, height_r;
  logic [17:0] pitch_r;
  logic [5:0]  bpp_r;
  logic [31:0] base_r;

  logic [PIXELS-1:0] rem_r, glyph_r;
  logic [23:0]       fore_r, back_r;
  logic [15:0]       oy_r;
  logic [2:0]        bytes_r;
  logic [18:0]       col_base_r, col_off_r;
  logic [31:0]       row_addr_r;
  logic [COL_W-1:0]  col_r;
  logic              out_valid_r;
  out_beat_t         out_data_r;

  logic [PIXELS-1:0] mask;
  logic [CELL-1:0]   row_ok, col_ok;
  logic              cmd_ok, transp;
  logic [2:0]        bytes;
  logic [18:0]       ox_scaled;
  logic              emit;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
      pitch_r  <= '0;
      bpp_r    <= '0;
      base_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  width_r  <= cfg_wdata[15:0];
        REG_SCREEN_HEIGHT: height_r <= cfg_wdata[15:0];
        REG_ROW_PITCH:     pitch_r  <= cfg_wdata[17:0];
        REG_BPP:           bpp_r    <= cfg_wdata[5:0];
        REG_FRAME_BASE:    base_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // per-row and per-column clip tests, then the mask of pixels to write
  always_comb begin
    cmd_ok = ((bpp_r == BPP_24) || (bpp_r == BPP_32)) && !in_data.char_code[7];
    transp = (in_data.back_color == TRANSPARENT);
    for (int i = 0; i < CELL; i++) begin
      row_ok[i] = (({1'b0, in_data.origin_y} + 17'(i)) < {1'b0, height_r});
      col_ok[i] = (({1'b0, in_data.origin_x} + 17'(i)) < {1'b0, width_r});
    end
    mask = '0;
    for (int r = 0; r < CELL; r++) begin
      for (int c = 0; c < CELL; c++) begin
        mask[r*ROW_STRIDE + c] = cmd_ok && row_ok[r] && col_ok[c] &&
                                 (in_data.glyph_bits[r*ROW_STRIDE + c] || !transp);
      end
    end
  end

  // bytes per pixel and the first column offset
  assign bytes = bpp_r[5:3];
  assign ox_scaled = (bpp_r == BPP_32) ? {1'b0, in_data.origin_x, 2'b00}
                                       : ({2'b00, in_data.origin_x, 1'b0} +
                                          {3'b000, in_data.origin_x});

  assign emit = cmd.step && rem_r[0];

  // command registers and pixel walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r      <= mask;
      glyph_r    <= in_data.glyph_bits;
      fore_r     <= in_data.fore_color[23:0];
      back_r     <= in_data.back_color[23:0];
      oy_r       <= in_data.origin_y;
      bytes_r    <= bytes;
      col_base_r <= ox_scaled;
      col_off_r  <= ox_scaled;
      col_r      <= '0;
    end else if (cmd.step) begin
      rem_r   <= rem_r >> 1;
      glyph_r <= glyph_r >> 1;
      col_r   <= col_r + 1'b1;
      if (col_r == COL_W'(ROW_STRIDE - 1)) begin
        col_off_r <= col_base_r;
      end else begin
        col_off_r <= col_off_r + {16'd0, bytes_r};
      end
    end
  end

  // row address: one multiply at start, then add the pitch per row
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      row_addr_r <= base_r + ({16'd0, oy_r} * {14'd0, pitch_r});
    end else if (cmd.step && (col_r == COL_W'(ROW_STRIDE - 1))) begin
      row_addr_r <= row_addr_r + {14'd0, pitch_r};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.write_address <= row_addr_r + {13'd0, col_off_r};
      out_data_r.write_color   <= glyph_r[0] ? fore_r : back_r;
      out_data_r.last_write    <= (rem_r[PIXELS-1:1] == '0);
    end
  end

  assign sts.rem_zero = (rem_r == '0);
  assign sts.step_ok  = !rem_r[0] || !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: sv/gb8_checker.sv
// port-level checker for the glyph blitter and its bind
`default_nettype none
module gb8_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire gb8_pkg::out_beat_t out_data,
  input wire logic               out_valid,
  input wire logic               out_stall
);
  import gb8_pkg::*;

  // a stalled write beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("out beat changed while stalled");

  // one command at a time: accepting a beat closes the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after accept");

  // nothing leaves the block just after reset
  a_quiet_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("out_valid right after reset");

  // once idle, any write still waiting must close its command
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !in_stall) |-> out_data.last_write)
    else $error("idle with a non-final write pending");

endmodule

bind glyph_blit_8x8_top gb8_checker u_gb8_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
`default_nettype wire

// File: sim/glyph_blit_8x8_top_tb.sv
// self-checking testbench for the 8x8 glyph blitter: predicts pixel writes per command
`default_nettype none
module glyph_blit_8x8_top_tb;
  import gb8_pkg::*;

  localparam int          DRAIN_CYCLES   = 80;    // longer than one full walk
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          RESET_CYCLES   = 11;
  localparam int          RAND_PHASES    = 10;
  localparam int          PHASE_ITEMS    = 30;
  localparam logic [7:0]  CODE_LIMIT     = 8'd128;
  localparam logic [2:0]  REG_UNMAPPED_LO = 3'd5;
  localparam logic [2:0]  REG_UNMAPPED_HI = 3'd7;
  localparam logic [63:0] GLYPH_FULL     = 64'hFFFF_FFFF_FFFF_FFFF;

  // predicts the framebuffer writes of each draw command and checks them in order
  class blit_scoreboard;
    logic [15:0] scr_w;
    logic [15:0] scr_h;
    logic [17:0] pitch;
    logic [5:0]  depth;
    logic [31:0] base;
    out_beat_t   expected_writes[$];
    int          errors;

    function new();
      scr_w = '0;
      scr_h = '0;
      pitch = '0;
      depth = '0;
      base = '0;
      errors = 0;
    endfunction

    // register update, masked to each register's width
    function void apply_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_SCREEN_WIDTH:  scr_w = val[15:0];
        REG_SCREEN_HEIGHT: scr_h = val[15:0];
        REG_ROW_PITCH:     pitch = val[17:0];
        REG_BPP:           depth = val[5:0];
        REG_FRAME_BASE:    base = val;
        default: ;
      endcase
    endfunction

    // walk the cell and queue one write per visible, non-transparent pixel
    function void predict_pixel_writes(in_beat_t cmd);
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] step;
      logic [31:0] color;
      out_beat_t   held;
      bit          have_held;
      bit          lit;
      bit          see_through;
      have_held = 0;
      held = '0;
      if (depth != BPP_24 && depth != BPP_32) return;
      if (cmd.char_code >= CODE_LIMIT) return;
      see_through = (cmd.back_color == TRANSPARENT);
      step = {26'd0, depth} >> 3;
      for (int r = 0; r < CELL; r++) begin
        y = {16'd0, cmd.origin_y} + r;
        for (int c = 0; c < CELL; c++) begin
          x = {16'd0, cmd.origin_x} + c;
          lit = cmd.glyph_bits[8 * r + c];
          if (!lit && see_through) continue;
          if (x >= {16'd0, scr_w} || y >= {16'd0, scr_h}) continue;
          color = lit ? cmd.fore_color : cmd.back_color;
          if (have_held) expected_writes.push_back(held);
          held.write_address = base + y * {14'd0, pitch} + x * step;
          held.write_color = color[23:0];
          held.last_write = 1'b0;
          have_held = 1;
        end
      end
      // only the final write of the command carries last_write
      if (have_held) begin
        held.last_write = 1'b1;
        expected_writes.push_back(held);
      end
    endfunction

    function void check_pixel_write(out_beat_t got);
      out_beat_t want;
      if (expected_writes.size() == 0) begin
        $error("unexpected write beat: address %h color %h last %b",
               got.write_address, got.write_color, got.last_write);
        errors++;
        return;
      end
      want = expected_writes.pop_front();
      if (got.write_address !== want.write_address) begin
        $error("write_address expected %h actual %h", want.write_address, got.write_address);
        errors++;
      end
      if (got.write_color !== want.write_color) begin
        $error("write_color expected %h actual %h", want.write_color, got.write_color);
        errors++;
      end
      if (got.last_write !== want.last_write) begin
        $error("last_write expected %b actual %b", want.last_write, got.last_write);
        errors++;
      end
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_beat_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  blit_scoreboard sb = new();
  bit no_idle;
  int out_hold;
  int quiet_cycles;

  glyph_blit_8x8_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock, period 12
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mirror register writes and accepted commands into the scoreboard
  always @(posedge clk) begin
    if (rst_n && cfg_we) sb.apply_reg(cfg_index, cfg_wdata);
    if (rst_n && in_valid && !in_stall) sb.predict_pixel_writes(in_data);
  end

  // write beats: check, then draw the stall before the next one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_pixel_write(out_data);
      out_hold = no_idle ? 0 : $urandom_range(0, 9);
    end
  end

  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no beat and no register write
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic in_beat_t make_cmd(logic [7:0] code, logic [63:0] glyph,
                                        logic [15:0] ox, logic [15:0] oy,
                                        logic [31:0] fg, logic [31:0] bg);
    in_beat_t cmd;
    cmd.char_code = code;
    cmd.glyph_bits = glyph;
    cmd.origin_x = ox;
    cmd.origin_y = oy;
    cmd.fore_color = fg;
    cmd.back_color = bg;
    return cmd;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_glyph();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return GLYPH_FULL;
      2: return rand64() & rand64() & rand64();
      3: return 64'({$urandom} & 32'hFF) << (8 * $urandom_range(0, 7));
      default: return rand64();
    endcase
  endfunction

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(0, 11))
      0: return 16'd0;
      1: return 16'd1;
      2, 3, 4, 5: return 16'($urandom_range(2, 700));
      6: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // origins mostly on or near the visible area so clipping edges get hit
  function automatic logic [15:0] pick_origin(logic [15:0] lim);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        if (lim >= 16'hFFFE) return 16'($urandom);
        return 16'($urandom_range(0, lim + 1));
      end
      5, 6: return lim - 16'($urandom_range(0, 8));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_back();
    case ($urandom_range(0, 9))
      0, 1, 2: return TRANSPARENT;
      3: return TRANSPARENT - 32'd1;
      4: return 32'h00FF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_beat_t random_cmd();
    logic [7:0] code;
    code = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 127))
                                        : 8'($urandom_range(128, 255));
    return make_cmd(code, pick_glyph(), pick_origin(sb.scr_w), pick_origin(sb.scr_h),
                    $urandom, pick_back());
  endfunction

  // offer one command beat and hold it until accepted
  task automatic send_cmd(in_beat_t cmd);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // wait until every predicted write is out and the walk has surely ended
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  // all five registers, with junk above the width of all but the frame base, plus an unmapped index
  task automatic load_config(logic [15:0] w, logic [15:0] h, logic [17:0] p,
                             logic [5:0] bpp, logic [31:0] fb);
    write_reg(REG_SCREEN_WIDTH, {16'($urandom), w});
    write_reg(REG_SCREEN_HEIGHT, {16'($urandom), h});
    write_reg(REG_ROW_PITCH, {14'($urandom), p});
    write_reg(REG_BPP, {26'($urandom), bpp});
    write_reg(REG_FRAME_BASE, fb);
    write_reg(3'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)), $urandom);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    logic [15:0] w;
    logic [17:0] p;
    logic [5:0]  bpp;
    logic [31:0] fb;
    w = pick_dim();
    case ($urandom_range(0, 4))
      0: p = 18'($urandom);
      1: p = 18'd0;
      2: p = 18'h3FFFF;
      default: p = 18'({2'b0, w} * 4);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: bpp = BPP_32;
      4, 5, 6, 7: bpp = BPP_24;
      default: bpp = 6'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: fb = 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
      1: fb = 32'd0;
      default: fb = $urandom;
    endcase
    load_config(w, pick_dim(), p, bpp, fb);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    out_hold = 0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    no_idle = 1'b0;
    quiet_cycles = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset config: zero depth and zero size, nothing may come out
    send_cmd(make_cmd(8'd0, GLYPH_FULL, 16'd0, 16'd0, 32'hFFFF_FFFF, 32'd0));
    send_cmd(make_cmd(8'd33, rand64(), 16'd0, 16'd0, $urandom, $urandom));
    settle();

    // ordinary 32-bit screen: code extremes, color extremes, clipped corners
    load_config(16'd640, 16'd480, 18'd2560, BPP_32, 32'h1000_0000);
    send_cmd(make_cmd(8'd0, GLYPH_FULL, 16'd0, 16'd0, 32'hFFFF_FFFF, 32'd0));
    send_cmd(make_cmd(8'd127, 64'd0, 16'd5, 16'd7, 32'd0, TRANSPARENT));
    send_cmd(make_cmd(CODE_LIMIT, GLYPH_FULL, 16'd0, 16'd0, $urandom, 32'd0));
    send_cmd(make_cmd(8'd255, rand64(), 16'd20, 16'd20, $urandom, $urandom));
    send_cmd(make_cmd(8'd65, 64'h8000_0000_0000_0001, 16'd10, 16'd10,
                      32'h00FF_0000, 32'h0000_FF00));
    send_cmd(make_cmd(8'd66, rand64(), 16'd636, 16'd476, $urandom, TRANSPARENT));
    send_cmd(make_cmd(8'd67, rand64(), 16'hFFFF, 16'hFFFF, $urandom, $urandom));
    send_cmd(make_cmd(8'd68, 64'hAA55_AA55_AA55_AA55, 16'd639, 16'd0, $urandom,
                      TRANSPARENT - 32'd1));
    send_cmd(make_cmd(8'd69, rand64(), 16'd0, 16'd479, $urandom, 32'h00FF_FFFF));
    settle();

    // largest screen, 24-bit, base near the top so addresses wrap
    no_idle = 1'b1;
    load_config(16'hFFFF, 16'hFFFF, 18'h3FFFF, BPP_24, 32'hFFFF_FFF0);
    send_cmd(make_cmd(8'd1, GLYPH_FULL, 16'd65530, 16'd65530, $urandom, $urandom));
    send_cmd(make_cmd(8'd2, rand64(), 16'd0, 16'd0, $urandom, $urandom));
    send_cmd(make_cmd(8'd3, rand64(), 16'hFFFF, 16'hFFFF, $urandom, $urandom));
    send_cmd(make_cmd(8'd127, GLYPH_FULL, 16'd0, 16'd65528, 32'hFFFF_FFFF, TRANSPARENT));
    settle();

    // zero width clips everything
    no_idle = 1'b0;
    load_config(16'd0, 16'hFFFF, 18'd256, BPP_32, 32'd0);
    send_cmd(make_cmd(8'd4, GLYPH_FULL, 16'd0, 16'd0, $urandom, $urandom));
    settle();

    // unsupported depth
    load_config(16'd8, 16'd8, 18'd0, 6'h3F, 32'd0);
    send_cmd(make_cmd(8'd5, GLYPH_FULL, 16'd0, 16'd0, $urandom, $urandom));
    settle();

    // one-pixel screen: two commands with a single write each, then a command with nothing written
    load_config(16'd1, 16'd1, 18'd1, BPP_24, 32'd0);
    send_cmd(make_cmd(8'd6, 64'd1, 16'd0, 16'd0, $urandom, $urandom));
    send_cmd(make_cmd(8'd7, GLYPH_FULL, 16'd0, 16'd0, $urandom, TRANSPARENT));
    send_cmd(make_cmd(8'd8, ~64'd1, 16'd0, 16'd0, $urandom, TRANSPARENT));
    settle();

    // random phases, each with its own config and idling mode
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      random_config();
      for (int i = 0; i < PHASE_ITEMS; i++) send_cmd(random_cmd());
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
sv/gb8_pkg.sv
sv/gb8_ctrl.sv
sv/gb8_dp.sv
sv/glyph_blit_8x8_top.sv
sv/gb8_checker.sv
sim/glyph_blit_8x8_top_tb.sv
